// File: rtl/lebc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lebc_pkg
// Shared types and constants for the line edit buffer with cursor.
// ----------------------------------------------------------------------------
package lebc_pkg;

  // Default line capacity in characters
  localparam int CAPACITY_DEF = 63;

  // Printable character range accepted by type
  localparam logic [7:0] PRINT_LOW  = 8'h20;
  localparam logic [7:0] PRINT_HIGH = 8'h7E;

  // Command codes; code 7 is unused and leaves the line unchanged
  typedef enum logic [2:0] {
    CMD_HOME  = 3'd0,
    CMD_END   = 3'd1,
    CMD_LEFT  = 3'd2,
    CMD_RIGHT = 3'd3,
    CMD_TYPE  = 3'd4,
    CMD_ERASE = 3'd5,
    CMD_PRINT = 3'd6
  } cmd_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_SHIFT,
    ST_INS_KEY,
    ST_DEL_SHIFT,
    ST_PR_STEP,
    ST_PR_DATA
  } state_t;

endpackage
`default_nettype wire

// File: rtl/line_edit_buffer_with_cursor_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// line_edit_buffer_with_cursor_top
// Bounded text line in a 1R1W synchronous memory with a cursor; a sequencer
// shifts entries for insert and erase and walks the memory for print.
// ----------------------------------------------------------------------------
// A non-print result is registered in the cycle after its beat.
// Throughput: one beat at a time; in_stall holds while the sequencer works or a result is stalled.
// Insert inside the line: each moved character is read and written one place up, then the key;
// erase inside the line: each moved character is read and written one place down (single memory port).
// Print: each character is read, then sent, and the cursor mark is its own beat; out_stall holds the walk.
// Reset clears length, cursor and sequencer; the text memory is not cleared.
module line_edit_buffer_with_cursor_top #(
  parameter int CAPACITY = lebc_pkg::CAPACITY_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] in_cmd,
  input  wire logic [7:0] in_key_byte,
  input  wire logic [7:0] in_separator_byte,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_accepted,
  output logic [7:0]      out_out_byte,
  output logic            out_byte_valid,
  output logic            out_last
);

  // length/cursor width holds 0..CAPACITY, address width indexes the store
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);
  localparam logic [LW-1:0] ONE_L = LW'(1);

  // text memory and its ports
  logic [6:0]    mem [CAPACITY];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [6:0]    mem_wd;
  logic          mem_re;
  logic [AW-1:0] mem_ra;
  logic [6:0]    rd_data_r;

  // control and working registers
  lebc_pkg::state_t state_r, state_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] cur_r, cur_nxt;
  logic [LW-1:0] ptr_r, ptr_nxt;
  logic [6:0]    key_r, key_nxt;
  logic [7:0]    sep_r, sep_nxt;
  logic          sep_done_r, sep_done_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic          acc_r, acc_nxt;
  logic [7:0]    obyte_r, obyte_nxt;
  logic          bvalid_r, bvalid_nxt;
  logic          last_r, last_nxt;

  logic          accept_in;
  logic          slot_free;
  logic          key_ok;
  logic [LW-1:0] ptr_inc;
  logic [LW-1:0] ptr_dec;
  logic          mark_at_end;

  assign in_stall  = (state_r != lebc_pkg::ST_IDLE) || (out_valid_r && out_stall);
  assign accept_in = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign key_ok    = (in_key_byte >= lebc_pkg::PRINT_LOW) &&
                     (in_key_byte <= lebc_pkg::PRINT_HIGH);
  assign ptr_inc   = ptr_r + ONE_L;
  assign ptr_dec   = ptr_r - ONE_L;
  // mark falls after the last character
  assign mark_at_end = (cur_r == len_r) && (sep_r != 8'd0);

  // memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lebc_pkg::ST_IDLE;
      len_r       <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
      sep_done_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
      sep_done_r  <= sep_done_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    key_r    <= key_nxt;
    sep_r    <= sep_nxt;
    acc_r    <= acc_nxt;
    obyte_r  <= obyte_nxt;
    bvalid_r <= bvalid_nxt;
    last_r   <= last_nxt;
  end

  // next state, memory control and result loading
  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    cur_nxt       = cur_r;
    ptr_nxt       = ptr_r;
    key_nxt       = key_r;
    sep_nxt       = sep_r;
    sep_done_nxt  = sep_done_r;
    out_valid_nxt = out_valid_r && out_stall;
    acc_nxt       = acc_r;
    obyte_nxt     = obyte_r;
    bvalid_nxt    = bvalid_r;
    last_nxt      = last_r;
    mem_we        = 1'b0;
    mem_wa        = AW'(cur_r);
    mem_wd        = key_r;
    mem_re        = 1'b0;
    mem_ra        = AW'(ptr_r);

    unique case (state_r)
      lebc_pkg::ST_IDLE: begin
        if (accept_in) begin
          // default single status beat
          out_valid_nxt = 1'b1;
          acc_nxt       = 1'b1;
          obyte_nxt     = 8'd0;
          bvalid_nxt    = 1'b0;
          last_nxt      = 1'b1;
          key_nxt       = in_key_byte[6:0];
          sep_nxt       = in_separator_byte;
          sep_done_nxt  = 1'b0;
          ptr_nxt       = '0;
          unique case (in_cmd)
            lebc_pkg::CMD_HOME: begin
              cur_nxt = '0;
            end
            lebc_pkg::CMD_END: begin
              cur_nxt = len_r;
            end
            lebc_pkg::CMD_LEFT: begin
              if (cur_r != '0) begin
                cur_nxt = cur_r - ONE_L;
              end
            end
            lebc_pkg::CMD_RIGHT: begin
              if (cur_r != len_r) begin
                cur_nxt = cur_r + ONE_L;
              end
            end
            lebc_pkg::CMD_TYPE: begin
              if (!key_ok || (len_r >= CAP_L)) begin
                acc_nxt = 1'b0;
              end else if (cur_r == len_r) begin
                // append: no shift needed
                mem_we  = 1'b1;
                mem_wa  = AW'(cur_r);
                mem_wd  = in_key_byte[6:0];
                len_nxt = len_r + ONE_L;
                cur_nxt = cur_r + ONE_L;
              end else begin
                // shift up from the top entry down to the cursor
                mem_re    = 1'b1;
                mem_ra    = AW'(len_r - ONE_L);
                ptr_nxt   = len_r - ONE_L;
                state_nxt = lebc_pkg::ST_INS_SHIFT;
              end
            end
            lebc_pkg::CMD_ERASE: begin
              if (cur_r == '0) begin
                acc_nxt = 1'b0;
              end else if (cur_r == len_r) begin
                len_nxt = len_r - ONE_L;
                cur_nxt = cur_r - ONE_L;
              end else begin
                // shift down from the cursor to the top entry
                mem_re    = 1'b1;
                mem_ra    = AW'(cur_r);
                ptr_nxt   = cur_r;
                state_nxt = lebc_pkg::ST_DEL_SHIFT;
              end
            end
            lebc_pkg::CMD_PRINT: begin
              if ((len_r != '0) || (in_separator_byte != 8'd0)) begin
                // real output comes from the walk
                out_valid_nxt = 1'b0;
                state_nxt     = lebc_pkg::ST_PR_STEP;
              end
            end
            default: begin
            end
          endcase
        end
      end

      lebc_pkg::ST_INS_SHIFT: begin
        mem_we = 1'b1;
        mem_wa = AW'(ptr_inc);
        mem_wd = rd_data_r;
        if (ptr_r == cur_r) begin
          state_nxt = lebc_pkg::ST_INS_KEY;
        end else begin
          mem_re  = 1'b1;
          mem_ra  = AW'(ptr_dec);
          ptr_nxt = ptr_dec;
        end
      end

      lebc_pkg::ST_INS_KEY: begin
        mem_we    = 1'b1;
        mem_wa    = AW'(cur_r);
        mem_wd    = key_r;
        len_nxt   = len_r + ONE_L;
        cur_nxt   = cur_r + ONE_L;
        state_nxt = lebc_pkg::ST_IDLE;
      end

      lebc_pkg::ST_DEL_SHIFT: begin
        mem_we = 1'b1;
        mem_wa = AW'(ptr_dec);
        mem_wd = rd_data_r;
        if (ptr_inc == len_r) begin
          len_nxt   = len_r - ONE_L;
          cur_nxt   = cur_r - ONE_L;
          state_nxt = lebc_pkg::ST_IDLE;
        end else begin
          mem_re  = 1'b1;
          mem_ra  = AW'(ptr_inc);
          ptr_nxt = ptr_inc;
        end
      end

      lebc_pkg::ST_PR_STEP: begin
        if ((ptr_r == cur_r) && (sep_r != 8'd0) && !sep_done_r) begin
          // cursor mark beat
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            acc_nxt       = 1'b1;
            obyte_nxt     = sep_r;
            bvalid_nxt    = 1'b1;
            last_nxt      = (cur_r == len_r);
            sep_done_nxt  = 1'b1;
            if (cur_r == len_r) begin
              state_nxt = lebc_pkg::ST_IDLE;
            end
          end
        end else if (ptr_r != len_r) begin
          mem_re    = 1'b1;
          mem_ra    = AW'(ptr_r);
          state_nxt = lebc_pkg::ST_PR_DATA;
        end else begin
          state_nxt = lebc_pkg::ST_IDLE;
        end
      end

      lebc_pkg::ST_PR_DATA: begin
        // character beat from the held read data
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          acc_nxt       = 1'b1;
          obyte_nxt     = {1'b0, rd_data_r};
          bvalid_nxt    = 1'b1;
          last_nxt      = (ptr_inc == len_r) && !mark_at_end;
          ptr_nxt       = ptr_inc;
          if ((ptr_inc == len_r) && !mark_at_end) begin
            state_nxt = lebc_pkg::ST_IDLE;
          end else begin
            state_nxt = lebc_pkg::ST_PR_STEP;
          end
        end
      end

      default: begin
        state_nxt = lebc_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_accepted   = acc_r;
  assign out_out_byte   = obyte_r;
  assign out_byte_valid = bvalid_r;
  assign out_last       = last_r;

endmodule
`default_nettype wire
